[rtl/ets_pkg.sv]
package ets_pkg;

    localparam int EPOCH_YEAR_DEF = 1970;

    localparam int TS_W       = 31;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;

    localparam int YEAR_W  = 11;
    localparam int MONTH_W = 4;
    localparam int DOM_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int WDAY_W  = 3;

    // full year, day number from year 1, year offset from epoch
    localparam int YR_W   = 12;
    localparam int ABS_W  = 20;
    localparam int OFS_W  = 7;
    localparam int DAYS_W = 15;
    localparam int SOD_W  = 17;
    localparam int SOH_W  = 12;
    localparam int DOY_W  = 9;
    localparam int MIDX_W = 4;

    localparam int SEC_PER_DAY  = 86400;
    localparam int SEC_PER_HOUR = 3600;
    localparam int SEC_PER_MIN  = 60;
    localparam int MONTHS       = 12;

    // reciprocals for exact division by constants
    localparam logic [24:0] RCP_DAY  = 25'd25451659;
    localparam int          SH_DAY   = 34;
    localparam logic [13:0] RCP_HOUR = 14'd9321;
    localparam int          SH_HOUR  = 21;
    localparam logic [10:0] RCP_MIN  = 11'd1093;
    localparam int          SH_MIN   = 14;
    localparam logic [20:0] RCP_WEEK = 21'd1198373;
    localparam int          SH_WEEK  = 23;
    localparam logic [10:0] RCP_25   = 11'd1311;
    localparam int          SH_25    = 15;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
        logic [WDAY_W-1:0] weekday;
    } tod_t;

    typedef struct packed {
        logic [ABS_W-1:0] target;
        logic [OFS_W-1:0] ofs;
        logic [ABS_W-1:0] base;
        tod_t             tod;
    } ysearch_t;

    function automatic logic [5:0] div25(input logic [9:0] v);
        logic [20:0] p;
        p = 21'(v) * 21'(RCP_25);
        return p[20:SH_25];
    endfunction

    // days from 1 january of year 1 to 1 january of y
    function automatic logic [ABS_W-1:0] days_before_year(input logic [YR_W-1:0] y);
        logic [YR_W-1:0]  p;
        logic [ABS_W-1:0] acc;
        p   = y - YR_W'(1);
        acc = ABS_W'(p) * ABS_W'(365);
        acc = acc + ABS_W'(p[YR_W-1:2]) - ABS_W'(div25(p[YR_W-1:2]))
            + ABS_W'(div25(10'(p[YR_W-1:4])));
        return acc;
    endfunction

    function automatic logic is_leap(input logic [YR_W-1:0] y);
        logic [9:0] q4;
        logic [9:0] q16;
        logic       by4;
        logic       by100;
        logic       by400;
        q4    = y[YR_W-1:2];
        q16   = 10'(y[YR_W-1:4]);
        by4   = (y[1:0] == 2'd0);
        by100 = by4 && ((10'(div25(q4)) * 10'(25)) == q4);
        by400 = (y[3:0] == 4'd0) && ((10'(div25(q16)) * 10'(25)) == q16);
        return by4 && (!by100 || by400);
    endfunction

    // first day of month m (0 is january) within the year
    function automatic logic [DOY_W-1:0] month_start(input logic [MIDX_W-1:0] m,
                                                     input logic leap);
        logic [DOY_W-1:0] s;
        case (m)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd59;
            4'd3:    s = 9'd90;
            4'd4:    s = 9'd120;
            4'd5:    s = 9'd151;
            4'd6:    s = 9'd181;
            4'd7:    s = 9'd212;
            4'd8:    s = 9'd243;
            4'd9:    s = 9'd273;
            4'd10:   s = 9'd304;
            4'd11:   s = 9'd334;
            default: s = 9'd0;
        endcase
        if (leap && (m >= 4'd2))
        begin
            s = s + 9'd1;
        end
        return s;
    endfunction

endpackage

[rtl/ets_year_step.sv]
module ets_year_step
    import ets_pkg::*;
#(
    parameter int EPOCH_YEAR = EPOCH_YEAR_DEF,
    parameter int BIT        = 0
)
(
    input  logic     clk,
    input  logic     en_cand,
    input  logic     en_pick,
    input  ysearch_t d,
    output ysearch_t q
);

    localparam logic [OFS_W-1:0] STEP = OFS_W'(1) << BIT;

    ysearch_t         cur_reg;
    logic [ABS_W-1:0] dc_reg;
    ysearch_t         q_reg;
    logic [OFS_W-1:0] ofs_c;
    logic [ABS_W-1:0] dc_next;
    ysearch_t         q_next;

    // start day of the candidate year
    always_comb
    begin
        ofs_c   = d.ofs | STEP;
        dc_next = days_before_year(YR_W'(EPOCH_YEAR) + YR_W'(ofs_c));
    end

    always_ff @(posedge clk)
    begin
        if (en_cand)
        begin
            cur_reg <= d;
            dc_reg  <= dc_next;
        end
    end

    // keep the candidate if its start is not past the target day
    always_comb
    begin
        q_next = cur_reg;
        if (dc_reg <= cur_reg.target)
        begin
            q_next.ofs  = cur_reg.ofs | STEP;
            q_next.base = dc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_pick)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

[rtl/epoch_seconds_to_calendar.sv]
// Converts a 31-bit count of seconds since midnight of 1 January of EPOCH_YEAR (UTC) into a
// Gregorian date and time with weekday, 0 for Sunday. The block is a 23-stage pipeline: one
// word can be taken every cycle, unless m_tready is low while every stage holds a word.
// Seconds of the day, hour, minute and weekday come from multiplications by constant
// reciprocals in the first six stages; the year is found by a seven-step binary search
// over year offsets, two stages per step, against the day count from year 1; month and day
// of month take the last three stages. Empty stages fill even while the output waits, so
// a stall never drops or repeats a word. The year field holds the low 11 bits of the year.
module epoch_seconds_to_calendar
    import ets_pkg::*;
#(
    parameter int EPOCH_YEAR = EPOCH_YEAR_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // epoch_seconds
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata   // year, month, day_of_month, hour, minute,
                                            // second, weekday
);

    localparam int ST_DIV = 0;
    localparam int ST_SOD = 1;
    localparam int ST_HR  = 2;
    localparam int ST_RH  = 3;
    localparam int ST_MN  = 4;
    localparam int ST_SC  = 5;
    localparam int ST_YS  = 6;
    localparam int ST_YR  = ST_YS + 2 * OFS_W;
    localparam int ST_MO  = ST_YR + 1;
    localparam int ST_OUT = ST_MO + 1;
    localparam int NS     = ST_OUT + 1;

    localparam logic [ABS_W-1:0] EPOCH_DAYS = days_before_year(YR_W'(EPOCH_YEAR));

    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] v_in;
    logic [NS-1:0] en;

    // stage flow: a stage loads when empty or when its word moves on
    assign en[NS-1] = !v_reg[NS-1] || m_tready;
    genvar gi;
    generate
        for (gi = 0; gi < NS - 1; gi++)
        begin : g_en
            assign en[gi] = !v_reg[gi] || en[gi+1];
        end
    endgenerate

    assign v_in   = {v_reg[NS-2:0], s_tvalid};
    assign v_next = (en & v_in) | (~en & v_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[NS-1];

    // days and seconds of day
    logic [TS_W-1:0]   ts0_reg;
    logic [DAYS_W-1:0] days0_reg;
    logic [48:0]       dprod;

    assign dprod = 49'(s_tdata[TS_W-1:7]) * 49'(RCP_DAY);

    always_ff @(posedge clk)
    begin
        if (en[ST_DIV])
        begin
            ts0_reg   <= s_tdata[TS_W-1:0];
            days0_reg <= dprod[SH_DAY+DAYS_W-1:SH_DAY];
        end
    end

    logic [SOD_W-1:0] sod1_reg;
    logic [ABS_W-1:0] tgt1_reg;
    logic [TS_W-1:0]  sod_full;

    assign sod_full = ts0_reg - TS_W'(days0_reg) * TS_W'(SEC_PER_DAY);

    always_ff @(posedge clk)
    begin
        if (en[ST_SOD])
        begin
            sod1_reg <= sod_full[SOD_W-1:0];
            tgt1_reg <= EPOCH_DAYS + ABS_W'(days0_reg);
        end
    end

    // hour, and weekday quotient
    logic [HOUR_W-1:0] hour2_reg;
    logic [SOD_W-1:0]  sod2_reg;
    logic [ABS_W-1:0]  tgt2_reg;
    logic [ABS_W-1:0]  wv2_reg;
    logic [17:0]       wq2_reg;
    logic [26:0]       hprod;
    logic [ABS_W-1:0]  wv_next;
    logic [40:0]       wprod;

    assign hprod   = 27'(sod1_reg[SOD_W-1:4]) * 27'(RCP_HOUR);
    assign wv_next = tgt1_reg + ABS_W'(1);
    assign wprod   = 41'(wv_next) * 41'(RCP_WEEK);

    always_ff @(posedge clk)
    begin
        if (en[ST_HR])
        begin
            hour2_reg <= hprod[SH_HOUR+HOUR_W-1:SH_HOUR];
            sod2_reg  <= sod1_reg;
            tgt2_reg  <= tgt1_reg;
            wv2_reg   <= wv_next;
            wq2_reg   <= wprod[40:SH_WEEK];
        end
    end

    logic [SOH_W-1:0]  rem3_reg;
    logic [HOUR_W-1:0] hour3_reg;
    logic [WDAY_W-1:0] wday3_reg;
    logic [ABS_W-1:0]  tgt3_reg;
    logic [SOD_W-1:0]  rem_full;
    logic [ABS_W-1:0]  wday_full;

    assign rem_full  = sod2_reg - SOD_W'(hour2_reg) * SOD_W'(SEC_PER_HOUR);
    assign wday_full = wv2_reg - ABS_W'(wq2_reg) * ABS_W'(7);

    always_ff @(posedge clk)
    begin
        if (en[ST_RH])
        begin
            rem3_reg  <= rem_full[SOH_W-1:0];
            hour3_reg <= hour2_reg;
            wday3_reg <= wday_full[WDAY_W-1:0];
            tgt3_reg  <= tgt2_reg;
        end
    end

    logic [SOH_W-1:0]  rem4_reg;
    logic [MIN_W-1:0]  min4_reg;
    logic [HOUR_W-1:0] hour4_reg;
    logic [WDAY_W-1:0] wday4_reg;
    logic [ABS_W-1:0]  tgt4_reg;
    logic [20:0]       mprod;

    assign mprod = 21'(rem3_reg[SOH_W-1:2]) * 21'(RCP_MIN);

    always_ff @(posedge clk)
    begin
        if (en[ST_MN])
        begin
            rem4_reg  <= rem3_reg;
            min4_reg  <= mprod[SH_MIN+MIN_W-1:SH_MIN];
            hour4_reg <= hour3_reg;
            wday4_reg <= wday3_reg;
            tgt4_reg  <= tgt3_reg;
        end
    end

    tod_t             tod5_reg;
    logic [ABS_W-1:0] tgt5_reg;
    logic [SOH_W-1:0] sec_full;

    assign sec_full = rem4_reg - SOH_W'(min4_reg) * SOH_W'(SEC_PER_MIN);

    always_ff @(posedge clk)
    begin
        if (en[ST_SC])
        begin
            tod5_reg.hour    <= hour4_reg;
            tod5_reg.minute  <= min4_reg;
            tod5_reg.second  <= sec_full[SEC_W-1:0];
            tod5_reg.weekday <= wday4_reg;
            tgt5_reg         <= tgt4_reg;
        end
    end

    // year search, most significant offset bit first
    ysearch_t ys [OFS_W+1];

    always_comb
    begin
        ys[0].target = tgt5_reg;
        ys[0].ofs    = '0;
        ys[0].base   = EPOCH_DAYS;
        ys[0].tod    = tod5_reg;
    end

    genvar gj;
    generate
        for (gj = 0; gj < OFS_W; gj++)
        begin : g_year
            ets_year_step #(
                .EPOCH_YEAR (EPOCH_YEAR),
                .BIT        (OFS_W - 1 - gj)
            ) u_step (
                .clk     (clk),
                .en_cand (en[ST_YS+2*gj]),
                .en_pick (en[ST_YS+2*gj+1]),
                .d       (ys[gj]),
                .q       (ys[gj+1])
            );
        end
    endgenerate

    // day of year and leap flag
    logic [YR_W-1:0]  year20_reg;
    logic [DOY_W-1:0] doy20_reg;
    logic             leap20_reg;
    tod_t             tod20_reg;
    logic [YR_W-1:0]  year_next;
    logic [ABS_W-1:0] doy_full;

    assign year_next = YR_W'(EPOCH_YEAR) + YR_W'(ys[OFS_W].ofs);
    assign doy_full  = ys[OFS_W].target - ys[OFS_W].base;

    always_ff @(posedge clk)
    begin
        if (en[ST_YR])
        begin
            year20_reg <= year_next;
            doy20_reg  <= doy_full[DOY_W-1:0];
            leap20_reg <= is_leap(year_next);
            tod20_reg  <= ys[OFS_W].tod;
        end
    end

    // month by compare against month starts
    logic [MIDX_W-1:0] midx21_reg;
    logic [YR_W-1:0]   year21_reg;
    logic [DOY_W-1:0]  doy21_reg;
    logic              leap21_reg;
    tod_t              tod21_reg;
    logic [MIDX_W-1:0] midx_next;

    always_comb
    begin
        midx_next = '0;
        for (int k = 1; k < MONTHS; k++)
        begin
            if (doy20_reg >= month_start(MIDX_W'(k), leap20_reg))
            begin
                midx_next = MIDX_W'(k);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_MO])
        begin
            midx21_reg <= midx_next;
            year21_reg <= year20_reg;
            doy21_reg  <= doy20_reg;
            leap21_reg <= leap20_reg;
            tod21_reg  <= tod20_reg;
        end
    end

    // output word
    logic [YEAR_W-1:0]  year_reg;
    logic [MONTH_W-1:0] month_reg;
    logic [DOM_W-1:0]   dom_reg;
    tod_t               tod_reg;
    logic [DOY_W-1:0]   dom_full;

    assign dom_full = doy21_reg - month_start(midx21_reg, leap21_reg) + DOY_W'(1);

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            year_reg  <= year21_reg[YEAR_W-1:0];
            month_reg <= midx21_reg + MONTH_W'(1);
            dom_reg   <= dom_full[DOM_W-1:0];
            tod_reg   <= tod21_reg;
        end
    end

    assign m_tdata = {tod_reg.weekday, tod_reg.second, tod_reg.minute, tod_reg.hour,
                      dom_reg, month_reg, year_reg};

    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    a_doy_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ST_YR] |-> (doy20_reg < 9'd365) || (leap20_reg && (doy20_reg == 9'd365)))
        else $error("year search left day of year out of range");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (month_reg >= 4'd1) && (month_reg <= 4'd12) && (dom_reg != 5'd0))
        else $error("month or day of month out of range");

    a_tod_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (tod_reg.hour < 5'd24) && (tod_reg.minute < 6'd60)
                     && (tod_reg.second < 6'd60) && (tod_reg.weekday < 3'd7))
        else $error("time of day or weekday out of range");

endmodule

[sim/tb_top.sv]
module tb_top;
    import ets_pkg::*;

    localparam int EPOCH = EPOCH_YEAR_DEF;
    localparam int N_RANDOM = 550;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES = 40;
    localparam int SEC_DAY = 86400;
    localparam int DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    // one calendar word, year in the lowest bits
    typedef struct packed {
        logic [WDAY_W-1:0]  weekday;
        logic [SEC_W-1:0]   second;
        logic [MIN_W-1:0]   minute;
        logic [HOUR_W-1:0]  hour;
        logic [DOM_W-1:0]   mday;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } cal_t;

    class date_checker;
        cal_t pending_dates [$];
        int   errors;

        function bit leap_year(int unsigned y);
            return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        endfunction

        function cal_t to_calendar(logic [TS_W-1:0] stamp);
            int unsigned days;
            int unsigned sod;
            int unsigned yr;
            int unsigned mon;
            int unsigned mlen;
            int unsigned prev;
            int unsigned count;
            cal_t c;
            days = stamp / SEC_DAY;
            sod  = stamp % SEC_DAY;
            yr   = EPOCH;
            while (days >= (leap_year(yr) ? 366 : 365))
            begin
                days -= leap_year(yr) ? 366 : 365;
                yr++;
            end
            mon = 1;
            prev = yr - 1;
            count = prev * 365 + prev / 4 - prev / 100 + prev / 400;
            forever
            begin
                mlen = DAYS_IN_MONTH[mon - 1];
                if (mon == 2 && leap_year(yr))
                begin
                    mlen = 29;
                end
                if (days < mlen || mon == 12)
                begin
                    break;
                end
                days  -= mlen;
                count += mlen;
                mon++;
            end
            count += days + 1;
            c.year    = YEAR_W'(yr);
            c.month   = MONTH_W'(mon);
            c.mday    = DOM_W'(days + 1);
            c.hour    = HOUR_W'(sod / 3600);
            c.minute  = MIN_W'((sod % 3600) / 60);
            c.second  = SEC_W'((sod % 3600) % 60);
            c.weekday = WDAY_W'(count % 7);
            return c;
        endfunction

        function void note_timestamp(logic [TS_W-1:0] stamp);
            pending_dates.push_back(to_calendar(stamp));
        endfunction

        function int pending();
            return pending_dates.size();
        endfunction

        function void check_date(logic [OUT_DATA_W-1:0] word);
            cal_t  got;
            cal_t  want;
            bit    bad;
            string exp_s;
            string got_s;
            got = cal_t'(word);
            if (pending_dates.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("unexpected output word %h", word);
                end
                return;
            end
            want = pending_dates.pop_front();
            bad = (got.year != want.year) || (got.month != want.month)
                || (got.mday != want.mday) || (got.hour != want.hour)
                || (got.minute != want.minute) || (got.second != want.second)
                || (got.weekday != want.weekday);
            if (bad)
            begin
                errors++;
                if (errors <= 10)
                begin
                    exp_s = $sformatf("%0d-%0d-%0d %0d:%0d:%0d wd %0d", want.year,
                                      want.month, want.mday, want.hour, want.minute,
                                      want.second, want.weekday);
                    got_s = $sformatf("%0d-%0d-%0d %0d:%0d:%0d wd %0d", got.year,
                                      got.month, got.mday, got.hour, got.minute,
                                      got.second, got.weekday);
                    $display("mismatch: expected %s, got %s", exp_s, got_s);
                end
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // epoch_seconds, spare top bit
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // year, month, day_of_month, hour, minute, second, weekday

    bit hold_request;
    date_checker dates = new();

    epoch_seconds_to_calendar #(.EPOCH_YEAR(EPOCH)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * 200000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            dates.note_timestamp(s_tdata[TS_W-1:0]);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            dates.check_date(m_tdata);
        end
    end

    task automatic send_word(input logic [IN_DATA_W-1:0] w);
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic maybe_idle();
        while ($urandom_range(99) < 38)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            @(posedge clk);
        end
    endtask

    task automatic wait_all_dates();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (dates.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [IN_DATA_W-1:0] random_stamp();
        logic [IN_DATA_W-1:0] w;
        longint unsigned      d;
        int unsigned          y;
        int unsigned          ylim;
        d = 0;
        case ($urandom_range(3))
            0, 1:
            begin
                w = $urandom;
            end
            2:
            begin
                // around midnight
                d = longint'($urandom_range(24854)) * SEC_DAY;
                d += $urandom_range(1) ? SEC_DAY - 1 - $urandom_range(2) : $urandom_range(2);
                w = IN_DATA_W'(d);
            end
            default:
            begin
                // around new year or a month change
                ylim = $urandom_range(EPOCH + 1, 2037);
                for (y = EPOCH; y < ylim; y++)
                begin
                    d += dates.leap_year(y) ? 366 : 365;
                end
                if ($urandom_range(1))
                begin
                    d += DAYS_IN_MONTH[$urandom_range(1)] + (dates.leap_year(y) ? 28 : 27)
                       * $urandom_range(1);
                end
                d = d * SEC_DAY + $urandom_range(1) - 1 + (d == 0);
                w = IN_DATA_W'(d);
            end
        endcase
        w[IN_DATA_W-1] = ($urandom_range(9) == 0);
        return w;
    endfunction

    // stimulus
    initial
    begin
        logic [IN_DATA_W-1:0] directed_stamps [$];
        directed_stamps = '{
            32'd0, 32'h7FFF_FFFF, 32'd86399, 32'd86400, 32'd31535999, 32'd31536000,
            32'd68169600, 32'd94694399, 32'd946684799, 32'd951782400, 32'd951868800,
            32'd978220800, 32'd1456704000, 32'd2145916800, 32'h8000_0000,
            32'hFFFF_FFFF, 32'h5555_5555, 32'h2AAA_AAAA
        };
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_stamps[i])
        begin
            send_word(directed_stamps[i]);
            maybe_idle();
        end
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 120)
            begin
                hold_request = 1'b1;
            end
            if (n == 300)
            begin
                wait_all_dates();
            end
            send_word(random_stamp());
            // steady stream while the output is held off
            if (n < 100 || n >= 220)
            begin
                maybe_idle();
            end
        end
        wait_all_dates();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (dates.errors == 0 && dates.pending() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // output side
    initial
    begin
        int rx_cycle;
        rx_cycle = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_cycle += HOLD_CYCLES;
            end
            else if (rx_cycle >= 500 && rx_cycle < 750)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= 38);
            end
        end
    end

endmodule
